// ----- hdl/ordered_list_insert_delete_defines.svh -----
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Shared helpers for the concurrent checks of the ordered list block.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// The consequent must hold in the cycle after the antecedent.
`define OLI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

// ----- hdl/oli_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered list package
// Widths, command and status codes, chain operations and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package oli_pkg;

    // Number of entries the list can hold.
    localparam int CAPACITY = 16;

    localparam int VAL_W  = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 5;
    localparam int ST_W   = 2;
    localparam int FILL_W = 5;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INS_FIRST = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_LAST  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ENUM      = 3'd6;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    // Operations broadcast along the cell chain.
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        idx;
        logic [IDX_W-1:0]        last;
        logic signed [VAL_W-1:0] value;
    } t_chain_ctl;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_in_req;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] entry_value;
        logic [FILL_W-1:0]       fill_count;
        logic                    last_result;
    } t_out_res;

endpackage

`default_nettype wire

// ----- hdl/oli_cell.sv -----
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry and takes its next value from itself, a neighbor, the
// head of the chain or the inserted value, as the broadcast operation says.
// ----------------------------------------------------------------------------
`default_nettype none

module oli_cell
    import oli_pkg::*;
(
    input  logic                    i_clk,
    input  logic [IDX_W-1:0]        i_index,
    input  t_chain_ctl              i_ctl,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    input  logic signed [VAL_W-1:0] i_first,
    output logic signed [VAL_W-1:0] o_value
);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;

    // Select the next entry for this position of the chain.
    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            OP_INS: begin
                if (i_index > i_ctl.idx) begin
                    n_value = i_left;
                end else if (i_index == i_ctl.idx) begin
                    n_value = i_ctl.value;
                end
            end
            OP_DEL: begin
                if (i_index >= i_ctl.idx) begin
                    n_value = i_right;
                end
            end
            OP_ROT: begin
                if (i_index < i_ctl.last) begin
                    n_value = i_right;
                end else if (i_index == i_ctl.last) begin
                    n_value = i_first;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- hdl/oli_chain.sv -----
// ----------------------------------------------------------------------------
// Ordered list cell chain
// A row of cells, front entry in cell zero, linked to their neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module oli_chain
    import oli_pkg::*;
(
    input  logic                    i_clk,
    input  t_chain_ctl              i_ctl,
    output logic signed [VAL_W-1:0] o_head
);

    logic signed [VAL_W-1:0] w_vals [CAPACITY];

    // Build the row; the ends see zero beyond the chain.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;

        if (g == 0) begin : g_lo
            assign w_left = '0;
        end else begin : g_lo
            assign w_left = w_vals[g-1];
        end

        if (g == CAPACITY - 1) begin : g_hi
            assign w_right = '0;
        end else begin : g_hi
            assign w_right = w_vals[g+1];
        end

        oli_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctl   (i_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_first (w_vals[0]),
            .o_value (w_vals[g])
        );
    end

    assign o_head = w_vals[0];

endmodule

`default_nettype wire

// ----- hdl/ordered_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// Ordered list with insert and delete
// Bounded list of signed entries kept in a shifting chain of cells, with
// insert and delete at either end or at a position, and enumeration.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  request   in         i_in_valid / o_in_ready     i_in_req  (t_in_req)
//  result    out        o_out_valid / i_out_ready   o_out_res (t_out_res)
//
// Insert, delete, unused codes and enumerate of an empty list give one result.
// Otherwise enumerate first enters its own state and then emits one entry per
// cycle unless stalled, as the chain rotates its head entry to the output register.
// A new request is taken only when no enumeration runs and the output
// register is free or being emptied. Reset empties the list at once.
// A stalled result holds the output register and the rotation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_insert_delete_defines.svh"

module ordered_list_insert_delete
    import oli_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_res o_out_res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_ENUM = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_k, n_k;
    logic             r_out_valid, n_out_valid;
    t_out_res         r_out, n_out;

    t_chain_ctl              w_ctl;
    logic signed [VAL_W-1:0] w_head;
    logic                    w_accept;
    logic                    w_out_free;
    logic [CMP_W-1:0]        w_pos;
    logic [CMP_W-1:0]        w_cnt;
    logic [CMP_W-1:0]        w_pos_m1;
    logic [CNT_W-1:0]        w_cnt_m1;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_enum_last;
    logic [ST_W-1:0]         w_status;

    oli_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    // Handshake and shared compare terms.
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_pos       = CMP_W'(i_in_req.position);
    assign w_cnt       = CMP_W'(r_count);
    assign w_pos_m1    = w_pos - CMP_W'(1);
    assign w_cnt_m1    = r_count - CNT_W'(1);
    assign w_full      = (r_count >= CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_enum_last = (r_k == w_cnt_m1);

    // Command decode, chain operation and result formation.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_status    = ST_OK;
        w_ctl.op    = OP_HOLD;
        w_ctl.idx   = '0;
        w_ctl.last  = w_cnt_m1[IDX_W-1:0];
        w_ctl.value = i_in_req.value;

        if (r_state == S_IDLE) begin
            if (w_accept) begin
                unique case (i_in_req.cmd)
                    CMD_INS_FIRST, CMD_INS_LAST: begin
                        if (w_full) begin
                            w_status = ST_FULL;
                        end else begin
                            w_ctl.op  = OP_INS;
                            w_ctl.idx = (i_in_req.cmd == CMD_INS_FIRST) ? '0
                                                                       : r_count[IDX_W-1:0];
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    CMD_INS_POS: begin
                        priority if (w_pos == '0 || w_pos > w_cnt + CMP_W'(1)) begin
                            w_status = ST_BADPOS;
                        end else if (w_full) begin
                            w_status = ST_FULL;
                        end else begin
                            w_ctl.op  = OP_INS;
                            w_ctl.idx = w_pos_m1[IDX_W-1:0];
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    CMD_DEL_FIRST, CMD_DEL_LAST: begin
                        if (w_empty) begin
                            w_status = ST_EMPTY;
                        end else begin
                            w_ctl.op  = OP_DEL;
                            w_ctl.idx = (i_in_req.cmd == CMD_DEL_FIRST) ? '0
                                                                       : w_cnt_m1[IDX_W-1:0];
                            n_count   = w_cnt_m1;
                        end
                    end
                    CMD_DEL_POS: begin
                        priority if (w_empty) begin
                            w_status = ST_EMPTY;
                        end else if (w_pos == '0 || w_pos > w_cnt) begin
                            w_status = ST_BADPOS;
                        end else begin
                            w_ctl.op  = OP_DEL;
                            w_ctl.idx = w_pos_m1[IDX_W-1:0];
                            n_count   = w_cnt_m1;
                        end
                    end
                    CMD_ENUM: begin
                        if (w_empty) begin
                            w_status = ST_EMPTY;
                        end
                    end
                    default: begin
                        w_status = ST_OK;
                    end
                endcase

                // A non-empty enumeration emits from its own state.
                if (i_in_req.cmd == CMD_ENUM && !w_empty) begin
                    n_state = S_ENUM;
                    n_k     = '0;
                end else begin
                    n_out_valid       = 1'b1;
                    n_out.status      = w_status;
                    n_out.entry_value = '0;
                    n_out.fill_count  = FILL_W'(n_count);
                    n_out.last_result = 1'b1;
                end
            end
        end else begin
            // Emit the head entry and rotate the next one into cell zero.
            if (w_out_free) begin
                w_ctl.op          = OP_ROT;
                n_out_valid       = 1'b1;
                n_out.status      = ST_OK;
                n_out.entry_value = w_head;
                n_out.fill_count  = FILL_W'(r_count);
                n_out.last_result = w_enum_last;
                n_k               = r_k + CNT_W'(1);
                if (w_enum_last) begin
                    n_state = S_IDLE;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // Checks on the list bookkeeping and the enumeration walk.
    `OLI_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `OLI_ASSERT_IMP(a_enum_nonempty, i_clk, i_rst_n, r_state == S_ENUM, r_count != '0)
    `OLI_ASSERT_IMP(a_enum_index, i_clk, i_rst_n, r_state == S_ENUM, r_k < r_count)
    `OLI_ASSERT_NXT(a_single_result, i_clk, i_rst_n,
        w_accept && i_in_req.cmd != CMD_ENUM, r_out_valid && r_out.last_result)

endmodule

`default_nettype wire
